// ===== hdl/slm_pkg.sv =====
// Shared types and constants for the slew-limited level bank.
// No dependencies; used by every module of the block.
`default_nettype none
package slm_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int LVL_W   = 16;
  localparam int RATE_W  = 24;
  localparam int TICK_W  = 21;
  localparam int PROD_W  = RATE_W + TICK_W;
  localparam int FRAC_SH = 20;
  localparam int OIDX_W  = 6;
  localparam int CFG_W   = 24;
  localparam int CFGI_W  = 2;

  localparam logic [LVL_W:0] LEVEL_ONE = 17'd32768;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_FAULT = 2'd2;

  localparam logic [CFGI_W-1:0] CFG_FIRST = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_DOWN  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_UP    = 2'd2;

  // one channel's stored state
  typedef struct packed {
    logic [LVL_W-1:0] tgt;
    logic             en;
    logic             flt;
    logic [LVL_W-1:0] app;
  } chan_entry_t;

  localparam int ENTRY_W = $bits(chan_entry_t);

endpackage
`default_nettype wire

// ===== hdl/multichannel_slew_limited_level_top.sv =====
// Top level of the slew-limited level bank: command sequencer and config.
// Depends on slm_pkg, slm_mem (channel state) and slm_step (step product).
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  input    | in_command .. in_global_enable          | start & !busy
//  result   | out_channel_index .. out_last           | out_strobe, one cycle
//  config   | cfg_index, cfg_data                     | cfg_we, no wait
//
// Tick: the shared step multiplier forms the down step, then the up step
// (S_MUL_DN, S_MUL_UP), S_TRD primes the memory read, then one channel per
// cycle read-modify-write, one result word per channel, last on the final one.
// Set and fault on a mapped id: busy for a read, then a write back,
// one result word. An unmapped id or unused code: one result word the next
// cycle, no busy time. Reset clears control state and the per-entry valid
// bits, so all channels read as zero without a clearing pass.
// The receiver cannot stall; each result word is shown for one cycle only.
`default_nettype none
module multichannel_slew_limited_level_top #(
  parameter int CHANNELS = slm_pkg::CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_command,
  input  wire logic [7:0]                    in_channel_id,
  input  wire logic signed [16:0]            in_target_level,
  input  wire logic                          in_enable,
  input  wire logic                          in_fault,
  input  wire logic [slm_pkg::TICK_W-1:0]    in_tick_time,
  input  wire logic                          in_global_enable,
  output logic                               out_strobe,
  output logic [slm_pkg::OIDX_W-1:0]         out_channel_index,
  output logic [slm_pkg::LVL_W-1:0]          out_applied_level,
  output logic                               out_accepted,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [slm_pkg::CFGI_W-1:0]    cfg_index,
  input  wire logic [slm_pkg::CFG_W-1:0]     cfg_data
);
  import slm_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_DN, S_MUL_UP, S_TRD, S_SWEEP, S_RD, S_WR
  } state_t;

  state_t state_r;

  // configuration registers
  logic [7:0]        first_r;
  logic [RATE_W-1:0] down_r;
  logic [RATE_W-1:0] up_r;

  // captured command word
  logic [1:0]        cmd_r;
  logic [IW-1:0]     idx_r;
  logic [LVL_W-1:0]  tgt_r;
  logic              en_r;
  logic              flt_r;
  logic [TICK_W-1:0] ticks_r;
  logic              gen_r;

  // step sizes for this tick
  logic [LVL_W:0] dn_step_r;
  logic [LVL_W:0] up_step_r;

  logic [RATE_W-1:0] rate_sel;
  logic [LVL_W:0]    step;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  chan_entry_t       mem_wentry;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  chan_entry_t       rd;

  logic [7:0]     loc8;
  logic           hit;
  logic           accept;
  logic [LVL_W-1:0] tgt_clamp;

  logic [LVL_W:0] want;
  logic [LVL_W:0] cur;
  logic [LVL_W:0] cur_nxt;
  logic [LVL_W:0] moved;

  slm_mem #(
    .DEPTH (CHANNELS),
    .AW    (IW),
    .DW    (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wentry),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  slm_step u_step (
    .clk   (clk),
    .rate  (rate_sel),
    .ticks (ticks_r),
    .step  (step)
  );

  assign rd     = chan_entry_t'(mem_rdata);
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // id to local index; unmapped ids fall outside the bank
  assign loc8 = in_channel_id - first_r;
  assign hit  = (in_channel_id >= first_r) && ({1'b0, loc8} < 9'(CHANNELS));

  always_comb begin
    if (in_target_level[16]) begin
      tgt_clamp = '0;
    end else if (in_target_level[15:0] > LEVEL_ONE[LVL_W-1:0] && 1'b1) begin
      tgt_clamp = LEVEL_ONE[LVL_W-1:0];
    end else begin
      tgt_clamp = in_target_level[15:0];
    end
  end

  assign rate_sel = (state_r == S_MUL_UP) ? up_r : down_r;

  // slew one channel toward its desired level
  always_comb begin
    cur  = {1'b0, rd.app};
    want = (gen_r && rd.en && !rd.flt) ? {1'b0, rd.tgt} : '0;
    if (want < cur) begin
      moved   = cur - dn_step_r;
      cur_nxt = ((cur - want) > dn_step_r) ? moved : want;
    end else begin
      moved   = cur + up_step_r;
      cur_nxt = ((want - cur) > up_step_r) ? moved : want;
    end
    if (cur_nxt > LEVEL_ONE) begin
      cur_nxt = LEVEL_ONE;
    end
  end

  // memory port control
  always_comb begin
    mem_re     = 1'b0;
    mem_raddr  = idx_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wentry = rd;
    unique case (state_r)
      S_TRD, S_RD: begin
        mem_re = 1'b1;
      end
      S_SWEEP: begin
        mem_re     = (idx_r != LAST_IDX);
        mem_raddr  = IW'(idx_r + 1'b1);
        mem_we     = 1'b1;
        mem_wentry.app = cur_nxt[LVL_W-1:0];
      end
      S_WR: begin
        mem_we = 1'b1;
        if (cmd_r == CMD_SET) begin
          mem_wentry.tgt = tgt_r;
          mem_wentry.en  = en_r;
        end else begin
          mem_wentry.flt = flt_r;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration writes; index three is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      down_r  <= RATE_W'(LEVEL_ONE);
      up_r    <= RATE_W'(LEVEL_ONE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST: first_r <= cfg_data[7:0];
        CFG_DOWN:  down_r  <= cfg_data;
        CFG_UP:    up_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // command payload and step size capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      tgt_r   <= tgt_clamp;
      en_r    <= in_enable;
      flt_r   <= in_fault;
      ticks_r <= in_tick_time;
      gen_r   <= in_global_enable;
    end
    if (state_r == S_MUL_UP) begin
      dn_step_r <= step;
    end
    if (state_r == S_TRD) begin
      up_step_r <= step;
    end
  end

  // sequencer and registered result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      idx_r             <= '0;
      out_strobe        <= 1'b0;
      out_channel_index <= '0;
      out_applied_level <= '0;
      out_accepted      <= 1'b0;
      out_last          <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_command == CMD_TICK) begin
              idx_r   <= '0;
              state_r <= S_MUL_DN;
            end else if ((in_command == CMD_SET || in_command == CMD_FAULT) && hit) begin
              idx_r   <= loc8[IW-1:0];
              state_r <= S_RD;
            end else begin
              out_strobe        <= 1'b1;
              out_channel_index <= '0;
              out_applied_level <= '0;
              out_accepted      <= 1'b0;
              out_last          <= 1'b1;
            end
          end
        end
        S_MUL_DN: state_r <= S_MUL_UP;
        S_MUL_UP: state_r <= S_TRD;
        S_TRD:    state_r <= S_SWEEP;
        S_SWEEP: begin
          out_strobe        <= 1'b1;
          out_channel_index <= OIDX_W'(idx_r);
          out_applied_level <= cur_nxt[LVL_W-1:0];
          out_accepted      <= 1'b1;
          out_last          <= (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= IW'(idx_r + 1'b1);
          end
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          out_strobe        <= 1'b1;
          out_channel_index <= OIDX_W'(idx_r);
          out_applied_level <= rd.app;
          out_accepted      <= 1'b1;
          out_last          <= 1'b1;
          state_r           <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/slm_mem.sv =====
// Channel state memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
`default_nettype none
module slm_mem #(
  parameter int DEPTH = slm_pkg::CHANNELS_DEF,
  parameter int AW    = $clog2(slm_pkg::CHANNELS_DEF),
  parameter int DW    = slm_pkg::ENTRY_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [DW-1:0] rd_r;
  logic          rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= valid_r[raddr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule
`default_nettype wire

// ===== hdl/slm_step.sv =====
// Slew step unit: registered rate * time product, then >>20 and saturate.
// Uses slm_pkg for widths and the full-scale level.
`default_nettype none
module slm_step (
  input  wire logic                      clk,
  input  wire logic [slm_pkg::RATE_W-1:0] rate,
  input  wire logic [slm_pkg::TICK_W-1:0] ticks,
  output logic      [slm_pkg::LVL_W:0]    step
);
  import slm_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-FRAC_SH-1:0] shifted;

  always_ff @(posedge clk) begin
    prod_r <= {{TICK_W{1'b0}}, rate} * {{RATE_W{1'b0}}, ticks};
  end

  assign shifted = prod_r[PROD_W-1:FRAC_SH];
  assign step = (shifted > (PROD_W-FRAC_SH)'(LEVEL_ONE)) ? LEVEL_ONE
                                                          : shifted[LVL_W:0];

endmodule
`default_nettype wire

// ===== test/slm_level_checker.sv =====
// Scoreboard for the slew-limited level bank: follows every accepted command
// word, keeps its own copy of channel state and checks each result word.
// Depends on slm_pkg for widths, command codes and register indexes.
module slm_level_checker #(
  parameter int CHANNELS = slm_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    in_command,
  input  logic [7:0]                    in_channel_id,
  input  logic signed [16:0]            in_target_level,
  input  logic                          in_enable,
  input  logic                          in_fault,
  input  logic [slm_pkg::TICK_W-1:0]    in_tick_time,
  input  logic                          in_global_enable,
  input  logic                          out_strobe,
  input  logic [slm_pkg::OIDX_W-1:0]    out_channel_index,
  input  logic [slm_pkg::LVL_W-1:0]     out_applied_level,
  input  logic                          out_accepted,
  input  logic                          out_last,
  input  logic                          cfg_we,
  input  logic [slm_pkg::CFGI_W-1:0]    cfg_index,
  input  logic [slm_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatch_count,
  output int                            words_pending
);
  import slm_pkg::*;

  typedef struct packed {
    logic [OIDX_W-1:0] idx;
    logic [LVL_W-1:0]  lvl;
    logic              acc;
    logic              last;
  } level_word_t;

  logic [7:0]        first_id;
  logic [RATE_W-1:0] fall_rate;
  logic [RATE_W-1:0] rise_rate;
  logic [LVL_W-1:0]  target_q [CHANNELS];
  logic [LVL_W-1:0]  level_q  [CHANNELS];
  logic              enable_q [CHANNELS];
  logic              fault_q  [CHANNELS];
  level_word_t       words_due [$];
  level_word_t       oldest_word;

  // largest move in one tick, saturated to full scale
  function automatic logic [LVL_W:0] slew_limit(input logic [RATE_W-1:0] rate,
                                                input logic [TICK_W-1:0] ticks);
    logic [PROD_W-1:0] prod;
    prod = (PROD_W'(rate) * PROD_W'(ticks)) >> FRAC_SH;
    if (prod > PROD_W'(LEVEL_ONE)) return LEVEL_ONE;
    return prod[LVL_W:0];
  endfunction

  task automatic predict_command(input logic [1:0] cmd, input logic [7:0] id,
                                 input logic signed [16:0] tgt, input logic en,
                                 input logic flt, input logic [TICK_W-1:0] tt,
                                 input logic ge);
    logic [LVL_W:0]   fall_step;
    logic [LVL_W:0]   rise_step;
    logic [LVL_W:0]   cur;
    logic [LVL_W:0]   want;
    logic [7:0]       chan_sel;
    logic [LVL_W-1:0] clamped;
    level_word_t      w;
    chan_sel = id - first_id;
    if (cmd == CMD_TICK) begin
      fall_step = slew_limit(fall_rate, tt);
      rise_step = slew_limit(rise_rate, tt);
      for (int i = 0; i < CHANNELS; i++) begin
        cur  = {1'b0, level_q[i]};
        want = (ge && enable_q[i] && !fault_q[i]) ? {1'b0, target_q[i]} : '0;
        if (want < cur) begin
          cur = ((cur - want) > fall_step) ? cur - fall_step : want;
        end else begin
          cur = ((want - cur) > rise_step) ? cur + rise_step : want;
        end
        if (cur > LEVEL_ONE) cur = LEVEL_ONE;
        level_q[i] = cur[LVL_W-1:0];
        w = '{idx: OIDX_W'(i), lvl: cur[LVL_W-1:0], acc: 1'b1, last: (i == CHANNELS - 1)};
        words_due.push_back(w);
      end
    end else if ((cmd == CMD_SET || cmd == CMD_FAULT) && id >= first_id &&
                 chan_sel < CHANNELS) begin
      if (cmd == CMD_SET) begin
        // negative requests read as zero, above full scale as full scale
        if (tgt[16]) clamped = '0;
        else if (tgt[15:0] > LEVEL_ONE[LVL_W-1:0]) clamped = LEVEL_ONE[LVL_W-1:0];
        else clamped = tgt[15:0];
        target_q[chan_sel] = clamped;
        enable_q[chan_sel] = en;
      end else begin
        fault_q[chan_sel] = flt;
      end
      w = '{idx: OIDX_W'(chan_sel), lvl: level_q[chan_sel], acc: 1'b1, last: 1'b1};
      words_due.push_back(w);
    end else begin
      // id outside the bank or spare code: empty word, not accepted
      w = '{idx: '0, lvl: '0, acc: 1'b0, last: 1'b1};
      words_due.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      first_id  = '0;
      fall_rate = RATE_W'(LEVEL_ONE);
      rise_rate = RATE_W'(LEVEL_ONE);
      for (int i = 0; i < CHANNELS; i++) begin
        target_q[i] = '0;
        level_q[i]  = '0;
        enable_q[i] = 1'b0;
        fault_q[i]  = 1'b0;
      end
      words_due.delete();
      mismatch_count = 0;
    end else begin
      // results first: a word leaving at this edge belongs to older commands
      if (out_strobe) begin
        if (words_due.size() == 0) begin
          $error("result word with none expected: channel_index %0d", out_channel_index);
          mismatch_count++;
        end else begin
          oldest_word = words_due.pop_front();
          if (out_channel_index !== oldest_word.idx) begin
            $error("channel_index: expected %0d, got %0d", oldest_word.idx,
                   out_channel_index);
            mismatch_count++;
          end
          if (out_applied_level !== oldest_word.lvl) begin
            $error("applied_level: expected %0d, got %0d", oldest_word.lvl,
                   out_applied_level);
            mismatch_count++;
          end
          if (out_accepted !== oldest_word.acc) begin
            $error("accepted: expected %0d, got %0d", oldest_word.acc, out_accepted);
            mismatch_count++;
          end
          if (out_last !== oldest_word.last) begin
            $error("last: expected %0d, got %0d", oldest_word.last, out_last);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST: first_id  = cfg_data[7:0];
          CFG_DOWN:  fall_rate = cfg_data[RATE_W-1:0];
          CFG_UP:    rise_rate = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_command(in_command, in_channel_id, in_target_level, in_enable, in_fault,
                        in_tick_time, in_global_enable);
      end
    end
    words_pending <= words_due.size();
  end

endmodule

// ===== test/multichannel_slew_limited_level_top_tb.sv =====
// Testbench top for the slew-limited level bank: drives command words and
// register writes, and gives the verdict from the checker's mismatch count.
// Depends on slm_pkg, multichannel_slew_limited_level_top and slm_level_checker.
module multichannel_slew_limited_level_top_tb;
  import slm_pkg::*;

  localparam int         CHANNELS    = CHANNELS_DEF;
  // slowest run is about 340 words, each with its busy time, plus
  // sender gaps and drain pauses; this is many times that
  localparam int         CYCLE_LIMIT = 200000;
  // the fourth command code has no meaning and must yield an empty word
  localparam logic [1:0] CMD_SPARE   = 2'd3;

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                start            = 1'b0;
  logic                busy;
  logic [1:0]          in_command       = '0;
  logic [7:0]          in_channel_id    = '0;
  logic signed [16:0]  in_target_level  = '0;
  logic                in_enable        = 1'b0;
  logic                in_fault         = 1'b0;
  logic [TICK_W-1:0]   in_tick_time     = '0;
  logic                in_global_enable = 1'b0;
  logic                out_strobe;
  logic [OIDX_W-1:0]   out_channel_index;
  logic [LVL_W-1:0]    out_applied_level;
  logic                out_accepted;
  logic                out_last;
  logic                cfg_we           = 1'b0;
  logic [CFGI_W-1:0]   cfg_index        = '0;
  logic [CFG_W-1:0]    cfg_data         = '0;

  int                  mismatch_count;
  int                  words_pending;
  int                  cycle_count      = 0;
  int                  sender_idle_pct  = 0;
  // local copy of the first id register, so random ids can be aimed into the bank
  logic [7:0]          bank_base        = '0;

  multichannel_slew_limited_level_top #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_channel_id    (in_channel_id),
    .in_target_level  (in_target_level),
    .in_enable        (in_enable),
    .in_fault         (in_fault),
    .in_tick_time     (in_tick_time),
    .in_global_enable (in_global_enable),
    .out_strobe       (out_strobe),
    .out_channel_index(out_channel_index),
    .out_applied_level(out_applied_level),
    .out_accepted     (out_accepted),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  slm_level_checker #(
    .CHANNELS(CHANNELS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_channel_id    (in_channel_id),
    .in_target_level  (in_target_level),
    .in_enable        (in_enable),
    .in_fault         (in_fault),
    .in_tick_time     (in_tick_time),
    .in_global_enable (in_global_enable),
    .out_strobe       (out_strobe),
    .out_channel_index(out_channel_index),
    .out_applied_level(out_applied_level),
    .out_accepted     (out_accepted),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .words_pending    (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** multichannel_slew_limited_level_top: FAILED **");
      $finish;
    end
  end

  // Present one command word and hold it until the edge that takes it
  // (start high, busy low). start is left high so back-to-back words need
  // no second assignment in one step; it drops for an idle gap or a drain.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] id,
                           input logic signed [16:0] tgt, input logic en,
                           input logic flt, input logic [TICK_W-1:0] tt,
                           input logic ge);
    int gap;
    start            <= 1'b1;
    in_command       <= cmd;
    in_channel_id    <= id;
    in_target_level  <= tgt;
    in_enable        <= en;
    in_fault         <= flt;
    in_tick_time     <= tt;
    in_global_enable <= ge;
    @(posedge clk);
    while (busy) @(posedge clk);
    // geometric gap: each cycle idles with the current probability
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected word is back and the block
  // is idle; words_pending is registered and lags the checker, so look after an edge.
  task automatic wait_all_words(input int tail);
    start <= 1'b0;
    do @(posedge clk); while (words_pending != 0 || busy);
    repeat (tail) @(posedge clk);
  endtask

  // Register writes only while the bank is idle.
  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_all_words(CHANNELS + 4);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_FIRST) bank_base = data[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic: sets and faults aimed into the bank, ticks
  // to move the levels, with some stray ids and spare codes mixed in.
  task automatic run_phase(input int count);
    int                 sel;
    int                 k;
    logic [1:0]         cmd;
    logic [7:0]         id;
    logic signed [16:0] tgt;
    logic               en;
    logic               flt;
    logic               ge;
    logic [TICK_W-1:0]  tt;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      id  = 8'($urandom_range(255));
      en  = ($urandom_range(3) != 0);
      flt = ($urandom_range(2) == 0);
      ge  = ($urandom_range(9) != 0);
      k   = $urandom_range(9);
      if (k < 5)      tgt = 17'($urandom_range(0, 32768));
      else if (k < 7) tgt = 17'($urandom_range(32769, 65535));
      else if (k < 9) tgt = 17'h10000 | 17'($urandom_range(65535));
      else            tgt = 17'($urandom_range(131071));
      k = $urandom_range(19);
      if (k < 10)      tt = TICK_W'($urandom_range(0, 4095));
      else if (k < 16) tt = TICK_W'($urandom_range(0, 65535));
      else if (k < 19) tt = TICK_W'($urandom_range(0, 1048576));
      else             tt = $urandom_range(1) ? TICK_W'(1048576) : '0;
      if (sel < 40) begin
        cmd = CMD_SET;
        id  = bank_base + 8'($urandom_range(CHANNELS - 1));
      end else if (sel < 48) begin
        cmd = CMD_SET;
      end else if (sel < 60) begin
        cmd = CMD_FAULT;
        id  = bank_base + 8'($urandom_range(CHANNELS - 1));
      end else if (sel < 65) begin
        cmd = CMD_FAULT;
      end else if (sel < 97) begin
        cmd = CMD_TICK;
      end else begin
        cmd = CMD_SPARE;
      end
      send_word(cmd, id, tgt, en, flt, tt, ge);
      // now and then hold off until the bank has drained
      if ($urandom_range(49) == 0) wait_all_words(0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at reset settings (first id 0, both rates 1.0 per second)
    send_word(CMD_SET,   8'd0,   17'sd32768,  1'b1, 1'b0, '0, 1'b1);
    send_word(CMD_SET,   8'd7,   17'sd65535,  1'b1, 1'b1, '0, 1'b1);  // clamps to 1.0
    send_word(CMD_SET,   8'd1,   17'sh10000,  1'b1, 1'b0, '0, 1'b0);  // most negative
    send_word(CMD_SET,   8'd2,  -17'sd1,      1'b1, 1'b0, '0, 1'b1);
    send_word(CMD_SET,   8'd3,   17'sd32767,  1'b0, 1'b0, '0, 1'b1);  // disabled
    send_word(CMD_SET,   8'd8,   17'sd1000,   1'b1, 1'b0, '0, 1'b1);  // just past bank
    send_word(CMD_SET,   8'd255, 17'sd1000,   1'b1, 1'b0, '0, 1'b1);
    send_word(CMD_FAULT, 8'd4,   17'sd0,      1'b0, 1'b1, '0, 1'b1);
    send_word(CMD_SET,   8'd4,   17'sd20000,  1'b1, 1'b0, '0, 1'b1);  // faulted channel
    send_word(CMD_SET,   8'd5,   17'sd16384,  1'b1, 1'b0, '0, 1'b1);
    send_word(CMD_SPARE, 8'd0,   17'sd0,      1'b1, 1'b1, '0, 1'b1);
    send_word(CMD_TICK,  8'd255, 17'sd0,      1'b0, 1'b0, TICK_W'(1024), 1'b1);
    send_word(CMD_TICK,  8'd0,   -17'sd1,     1'b1, 1'b1, '0, 1'b1);      // zero step
    send_word(CMD_TICK,  8'd0,   17'sd0,      1'b0, 1'b0, TICK_W'(1048576), 1'b1);
    send_word(CMD_TICK,  8'd0,   17'sd0,      1'b0, 1'b0, TICK_W'(16), 1'b0); // falling
    send_word(CMD_FAULT, 8'd4,   17'sd0,      1'b0, 1'b0, '0, 1'b1);
    send_word(CMD_FAULT, 8'd200, 17'sd0,      1'b0, 1'b1, '0, 1'b1);  // stray fault
    send_word(CMD_TICK,  8'd0,   17'sd0,      1'b0, 1'b0, TICK_W'(1), 1'b1);
    send_word(CMD_TICK,  8'd0,   17'sd0,      1'b0, 1'b0, TICK_W'(1048575), 1'b1);
    send_word(CMD_SET,   8'd6,   17'sd0,      1'b1, 1'b0, '0, 1'b1);
    send_word(CMD_TICK,  8'd0,   17'sd0,      1'b0, 1'b0, TICK_W'(2048), 1'b1);

    // Sender idles 13 percent: extreme rates, one direction frozen each time
    sender_idle_pct = 13;
    write_reg(CFG_FIRST, CFG_W'(0));
    write_reg(CFG_DOWN,  CFG_W'(0));
    write_reg(CFG_UP,    CFG_W'(24'hFFFFFF));
    run_phase(52);
    write_reg(CFG_FIRST, CFG_W'(255));  // only local channel zero reachable
    write_reg(CFG_DOWN,  CFG_W'(24'hFFFFFF));
    write_reg(CFG_UP,    CFG_W'(0));
    run_phase(52);

    // Sender idles 47 percent: partial bank at the top of the id range, then a bank at id 100
    sender_idle_pct = 47;
    write_reg(CFG_FIRST, CFG_W'(250));
    write_reg(CFG_DOWN,  CFG_W'(32768));
    write_reg(CFG_UP,    CFG_W'(65536));
    run_phase(52);
    write_reg(CFG_FIRST, CFG_W'(100));
    write_reg(CFG_DOWN,  CFG_W'($urandom_range(0, (1 << $urandom_range(8, 24)) - 1)));
    write_reg(CFG_UP,    CFG_W'($urandom_range(0, (1 << $urandom_range(8, 24)) - 1)));
    run_phase(52);

    // No idling at all
    sender_idle_pct = 0;
    write_reg(CFG_FIRST, CFG_W'(0));
    write_reg(CFG_DOWN,  CFG_W'($urandom_range(0, (1 << $urandom_range(8, 24)) - 1)));
    write_reg(CFG_UP,    CFG_W'($urandom_range(0, (1 << $urandom_range(8, 24)) - 1)));
    run_phase(52);
    write_reg(CFG_FIRST, CFG_W'($urandom_range(255)));
    write_reg(CFG_DOWN,  CFG_W'($urandom_range(0, (1 << $urandom_range(8, 24)) - 1)));
    write_reg(CFG_UP,    CFG_W'($urandom_range(0, (1 << $urandom_range(8, 24)) - 1)));
    run_phase(50);

    // drain, then let the last busy window close
    wait_all_words(CHANNELS + 4);
    if (mismatch_count == 0) begin
      $display("** multichannel_slew_limited_level_top: PASSED **");
    end else begin
      $display("** multichannel_slew_limited_level_top: FAILED **");
    end
    $finish;
  end

endmodule
